// File: src/fdec_pkg.sv
// Shared types and constants for the 3-to-2 FIR decimator.
// Holds the filter coefficients, sample and product types and the tap-cell control struct.
// No dependencies.
package fdec_pkg;

    // Filter shape.
    localparam int TAPS     = 16;
    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 32;
    localparam int ACC_W    = 34;
    localparam int GROUP_N  = 4;
    localparam int GROUPS   = TAPS / GROUP_N;

    // Phase accumulator and configuration widths.
    localparam int STEP_W  = 31;
    localparam int PHASE_W = 30;
    localparam int COUNT_W = 13;
    localparam int CFG_W   = 31;

    // Output scaling: Q15 products, keep bits [30:15] of the sum.
    localparam int OUT_SHIFT = 15;

    // Configuration register indexes.
    localparam logic CFG_PHASE_STEP  = 1'b0;
    localparam logic CFG_FRAME_LIMIT = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [STEP_W-1:0]  PHASE_STEP_RST  = 31'd715827883;
    localparam logic [COUNT_W-1:0] FRAME_LIMIT_RST = 13'd320;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [ACC_W-1:0]    t_acc;

    // Symmetric low-pass filter, Q15; index 0 multiplies the newest sample.
    localparam t_sample COEF [TAPS] = '{
        -16'sd128,  -16'sd256,  -16'sd512,  -16'sd1024,
        -16'sd2048, -16'sd3072,  16'sd8192,  16'sd28416,
         16'sd28416, 16'sd8192, -16'sd3072, -16'sd2048,
        -16'sd1024, -16'sd512,  -16'sd256,  -16'sd128
    };

    // Control that every tap cell sees for one beat.
    typedef struct packed {
        logic load;     // shift a new sample into the window
        logic zero_in;  // on load, take zero instead of the neighbor's sample
        logic clear;    // without load, clear the held sample
    } t_cell_ctl;

endpackage

// File: src/fdec_tap_cell.sv
// One tap of the sample window: holds one sample and its product with a coefficient.
// Hands its sample to the next cell on every load.
// Depends on fdec_pkg.
module fdec_tap_cell
    import fdec_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_sample   i_din,
    input  t_sample   i_coef,
    output t_sample   o_sample,
    output t_prod     o_prod
);

    t_sample r_sample;
    t_sample n_sample;
    t_prod   r_prod;

    // Next held sample: shift in, clear at frame start, or hold.
    always_comb begin
        if (i_ctl.load) begin
            n_sample = i_ctl.zero_in ? '0 : i_din;
        end else if (i_ctl.clear) begin
            n_sample = '0;
        end else begin
            n_sample = r_sample;
        end
    end

    // The window sample is state and resets to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else begin
            r_sample <= n_sample;
        end
    end

    // The product tracks the sample the cell holds after this edge.
    always_ff @(posedge i_clk) begin
        r_prod <= t_prod'(n_sample) * t_prod'(i_coef);
    end

    assign o_sample = r_sample;
    assign o_prod   = r_prod;

endmodule

// File: src/fdec_sum_tree.sv
// Two-stage adder tree over the tap products; the first stage is registered.
// Scales the sum down by 15 bits and wraps it to 16 bits.
// Depends on fdec_pkg.
module fdec_sum_tree
    import fdec_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_prod   i_prod [TAPS],
    output logic    o_valid,
    output t_sample o_sample
);

    t_acc r_part [GROUPS];
    t_acc n_part [GROUPS];
    logic r_valid;
    t_acc total;

    // First stage: sum each group of products.
    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            n_part[g] = '0;
            for (int k = 0; k < GROUP_N; k++) begin
                n_part[g] = n_part[g] + t_acc'(i_prod[g*GROUP_N + k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_part <= n_part;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // Second stage: add the group sums; the caller registers the result.
    always_comb begin
        total = '0;
        for (int g = 0; g < GROUPS; g++) begin
            total = total + r_part[g];
        end
    end

    assign o_valid  = r_valid;
    assign o_sample = total[OUT_SHIFT +: SAMPLE_W];

endmodule

// File: src/fdec_out_fifo.sv
// Small output queue that holds finished samples while the receiver stalls.
// Register-based circular buffer; the writer never overfills it.
// Depends on fdec_pkg.
module fdec_out_fifo
    import fdec_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_sample i_wdata,
    input  logic    i_rd,
    output logic    o_valid,
    output t_sample o_rdata
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    t_sample          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             rd_fire;

    assign rd_fire = i_rd && (r_count != '0);

    // Storage; entries need no reset.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_fire) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_wr && !rd_fire) begin
                r_count <= r_count + 1'b1;
            end else if (!i_wr && rd_fire) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd_ptr];

endmodule

// File: src/fir_decimator_3_to_2_unit.sv
// Fractional FIR resampler, 3 input samples to 2 output samples at the default step.
// Input channel: i_in_valid / o_in_stall with i_sample_in and i_frame_start.
// Output channel: o_out_valid / i_out_stall with o_sample_out.
// Configuration: i_cfg_we, i_cfg_index, i_cfg_data; index 0 is the Q30 phase step,
// index 1 the per-frame output limit. Write only while the block is idle.
// Throughput: one input beat per cycle, sustained, while the receiver keeps up.
// A sample that produces a result reaches the output through the tap cell registers,
// one registered adder stage and the output queue.
// Each beat the 16 tap cells shift and multiply in parallel; a two-stage adder tree
// sums the products. Finished samples wait in an OUT_DEPTH-entry queue. o_in_stall
// rises only when every queue entry is already reserved by a result in flight or
// waiting, so a stalled receiver costs no data; input resumes as soon as one is taken.
// Reset (synchronous, active low) clears the window, the phase, the output count and
// the queue, and loads the default step and limit. i_frame_start clears the window,
// phase and count before its own sample. Once the limit of outputs is reached in a
// frame, later samples of that frame are dropped.
// Depends on fdec_pkg, fdec_tap_cell, fdec_sum_tree and fdec_out_fifo.
module fir_decimator_3_to_2_unit
    import fdec_pkg::*;
#(
    parameter int OUT_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_sample_in,
    input  logic               i_frame_start,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_sample_out,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    localparam int USED_W = $clog2(OUT_DEPTH + 1);
    localparam logic [USED_W-1:0] USED_FULL = USED_W'(OUT_DEPTH);

    logic [STEP_W-1:0]  r_step;
    logic [COUNT_W-1:0] r_limit;
    logic [PHASE_W-1:0] r_phase;
    logic [COUNT_W-1:0] r_count;
    logic [USED_W-1:0]  r_used;
    logic               r_emit;

    logic               in_fire;
    logic               out_fire;
    logic               process;
    logic               clear_only;
    logic               emit;
    logic [PHASE_W-1:0] phase_base;
    logic [COUNT_W-1:0] count_base;
    logic [STEP_W:0]    phase_sum;

    t_sample   window [TAPS];
    t_prod     prod   [TAPS];
    t_cell_ctl head_ctl;
    t_cell_ctl body_ctl;
    logic      tree_valid;
    t_sample   tree_sample;

    assign in_fire  = i_in_valid && !o_in_stall;
    assign out_fire = o_out_valid && !i_out_stall;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= PHASE_STEP_RST;
            r_limit <= FRAME_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PHASE_STEP:  r_step  <= i_cfg_data;
                CFG_FRAME_LIMIT: r_limit <= i_cfg_data[COUNT_W-1:0];
                default:         r_step  <= r_step;
            endcase
        end
    end

    // Frame start clears phase and count before the sample is looked at.
    assign phase_base = i_frame_start ? '0 : r_phase;
    assign count_base = i_frame_start ? '0 : r_count;
    assign process    = in_fire && (count_base < r_limit);
    assign clear_only = in_fire && i_frame_start && !process;

    // The phase stays below one after every step, so 30 bits hold it; the
    // 31-bit wrap of the sum sits in bit 30, which marks an output.
    assign phase_sum = {2'b00, phase_base} + {1'b0, r_step};
    assign emit      = process && phase_sum[PHASE_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_count <= '0;
            r_emit  <= 1'b0;
        end else begin
            r_emit <= emit;
            if (process) begin
                r_phase <= phase_sum[PHASE_W-1:0];
                r_count <= emit ? count_base + 1'b1 : count_base;
            end else if (clear_only) begin
                r_phase <= '0;
                r_count <= '0;
            end
        end
    end

    // Queue entries reserved by results in flight or waiting.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (emit && !out_fire) begin
            r_used <= r_used + 1'b1;
        end else if (!emit && out_fire) begin
            r_used <= r_used - 1'b1;
        end
    end

    assign o_in_stall = (r_used == USED_FULL);

    // Tap cell chain: the head takes the new sample, the rest take their neighbor's.
    assign head_ctl = '{load: process, zero_in: 1'b0, clear: clear_only};
    assign body_ctl = '{load: process, zero_in: i_frame_start, clear: clear_only};

    fdec_tap_cell u_head (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (head_ctl),
        .i_din    (i_sample_in),
        .i_coef   (COEF[0]),
        .o_sample (window[0]),
        .o_prod   (prod[0])
    );

    for (genvar k = 1; k < TAPS; k++) begin : g_cell
        fdec_tap_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (body_ctl),
            .i_din    (window[k-1]),
            .i_coef   (COEF[k]),
            .o_sample (window[k]),
            .o_prod   (prod[k])
        );
    end

    // Sum the products of the window as it stands after the emitting beat.
    fdec_sum_tree u_tree (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_emit),
        .i_prod   (prod),
        .o_valid  (tree_valid),
        .o_sample (tree_sample)
    );

    fdec_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (tree_valid),
        .i_wdata (tree_sample),
        .i_rd    (!i_out_stall),
        .o_valid (o_out_valid),
        .o_rdata (o_sample_out)
    );

endmodule

// File: src/fdec_checker.sv
// Port-level checks for the 3-to-2 FIR decimator, bound to the top level.
// Watches the reset behavior, the output hold and the input-to-output timing.
// Depends on fir_decimator_3_to_2_unit.
module fdec_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [15:0] o_sample_out
);

    // Reset leaves the output empty and the input open.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output valid or input stall after reset");

    // A stalled output beat holds its sample.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sample_out))
        else $error("stalled output beat changed or vanished");

    // An output leaves only when the receiver takes it.
    a_out_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_out_valid) |-> $past(!i_out_stall))
        else $error("output dropped without being taken");

    // An empty queue fills only from an earlier input beat, through the tap cell, adder and queue registers.
    a_out_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 3))
        else $error("output appeared without a matching input beat");

endmodule

bind fir_decimator_3_to_2_unit fdec_checker u_fdec_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_sample_out (o_sample_out)
);

// File: bench/tb_top.sv
// Self-checking bench for fir_decimator_3_to_2_unit: a short table of directed beats,
// then random beats over several step and limit settings, checked against a resampler model.
// Depends on fdec_pkg and the fir_decimator_3_to_2_unit RTL.
`timescale 1ns / 100ps

module tb_top;
    import fdec_pkg::*;

    // How a directed row is checked: by the model, or against a value typed into the row.
    localparam logic CHK_PRED  = 1'b0;
    localparam logic CHK_TYPED = 1'b1;

    localparam logic [STEP_W-1:0] PHASE_UNITY = 31'h4000_0000;
    localparam logic [STEP_W-1:0] STEP_MAX    = 31'h7FFF_FFFF;
    localparam logic [STEP_W-1:0] STEP_THIRD  = 31'd357913941;
    localparam int ROW_N       = 20;
    localparam int SETTLE_CYC  = 8;
    localparam int MISMATCH_SHOWN = 10;
    localparam int SEND_IDLE_PCT [3] = '{27, 84, 0};
    localparam int RECV_IDLE_PCT [3] = '{84, 27, 0};

    typedef struct packed {
        t_sample smp;
        logic    fs;
        logic    chk;
        t_sample want;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    t_sample            i_sample_in = '0;
    logic               i_frame_start = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_sample            o_sample_out;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_index = CFG_PHASE_STEP;
    logic [CFG_W-1:0]   i_cfg_data = '0;

    // Side band that travels with each input beat: how its sample is to be checked.
    logic    beat_chk = CHK_PRED;
    t_sample beat_want = '0;

    // Resampler model state and its copy of the registers.
    t_sample              win [TAPS];
    logic [STEP_W-1:0]    phase;
    logic [COUNT_W-1:0]   emitted;
    logic [STEP_W-1:0]    step_reg;
    logic [COUNT_W-1:0]   limit_reg;
    t_sample              pending_samples [$];

    int      beats_sent = 0;
    int      mismatches = 0;
    int      idle_mode = 0;
    t_sample last_pick = '0;
    logic    fires;
    t_sample filtered;

    // Directed beats at the default step; sample extremes, frame starts and simple windows.
    t_row directed_rows [ROW_N] = '{
        '{16'sh8000,   1'b1, CHK_PRED,  16'sd0},
        '{16'sd0,      1'b0, CHK_TYPED, 16'sd256},
        '{16'sh7FFF,   1'b1, CHK_PRED,  16'sd0},
        '{16'sd0,      1'b0, CHK_TYPED, -16'sd256},
        '{16'sd0,      1'b1, CHK_PRED,  16'sd0},
        '{16'sd0,      1'b0, CHK_TYPED, 16'sd0},
        '{16'sh7FFF,   1'b0, CHK_PRED,  16'sd0},
        '{16'sh7FFF,   1'b0, CHK_PRED,  16'sd0},
        '{16'sh8000,   1'b0, CHK_PRED,  16'sd0},
        '{16'sh8000,   1'b0, CHK_PRED,  16'sd0},
        '{16'sd1,      1'b0, CHK_PRED,  16'sd0},
        '{-16'sd1,     1'b0, CHK_PRED,  16'sd0},
        '{16'sh5555,   1'b0, CHK_PRED,  16'sd0},
        '{16'shAAAA,   1'b0, CHK_PRED,  16'sd0},
        '{16'sh7FFF,   1'b1, CHK_PRED,  16'sd0},
        '{16'sd0,      1'b0, CHK_PRED,  16'sd0},
        '{16'sh8000,   1'b0, CHK_PRED,  16'sd0},
        '{16'sh7FFF,   1'b0, CHK_PRED,  16'sd0},
        '{16'sd255,    1'b0, CHK_PRED,  16'sd0},
        '{-16'sd256,   1'b0, CHK_PRED,  16'sd0}
    };

    fir_decimator_3_to_2_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_sample_in   (i_sample_in),
        .i_frame_start (i_frame_start),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_sample_out  (o_sample_out),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Clear the window, the phase and the per-frame count.
    task automatic clear_frame_state();
        for (int k = 0; k < TAPS; k++) begin
            win[k] = '0;
        end
        phase   = '0;
        emitted = '0;
    endtask

    // Accepted sample: clear on frame start; under the limit shift in, step phase, filter at one.
    task automatic advance_resampler(input t_sample s, input logic fs,
                                     output logic fire, output t_sample y);
        longint sum;
        sum  = 0;
        fire = 1'b0;
        y    = '0;
        if (fs) begin
            clear_frame_state();
        end
        if (emitted < limit_reg) begin
            for (int k = TAPS - 1; k > 0; k--) begin
                win[k] = win[k-1];
            end
            win[0] = s;
            phase  = phase + step_reg;
            if (phase >= PHASE_UNITY) begin
                phase = phase - PHASE_UNITY;
                for (int k = 0; k < TAPS; k++) begin
                    sum += longint'(win[k]) * longint'(COEF[k]);
                end
                y       = t_sample'(sum >>> OUT_SHIFT);
                fire    = 1'b1;
                emitted = emitted + 1'b1;
            end
        end
    endtask

    task automatic note_mismatch(input t_sample want, input t_sample got);
        mismatches++;
        if (mismatches <= MISMATCH_SHOWN) begin
            $display("sample_out mismatch at %0t: expected %0d, got %0d", $time, want, got);
        end
    endtask

    // Follows registers and accepted input beats, predicts samples, checks output beats.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_frame_state();
            step_reg  = PHASE_STEP_RST;
            limit_reg = FRAME_LIMIT_RST;
            pending_samples.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_PHASE_STEP) begin
                    step_reg = i_cfg_data[STEP_W-1:0];
                end else begin
                    limit_reg = i_cfg_data[COUNT_W-1:0];
                end
            end
            if (i_in_valid && !o_in_stall) begin
                advance_resampler(i_sample_in, i_frame_start, fires, filtered);
                if (fires) begin
                    pending_samples.push_back(beat_chk == CHK_TYPED ? beat_want : filtered);
                end
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_samples.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MISMATCH_SHOWN) begin
                        $display("unexpected output beat at %0t: %0d", $time, o_sample_out);
                    end
                end else begin
                    filtered = pending_samples.pop_front();
                    if (o_sample_out !== filtered) begin
                        note_mismatch(filtered, o_sample_out);
                    end
                end
            end
        end
    end

    // Receiver: stalls at random at the rate of the current idling mode.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < RECV_IDLE_PCT[idle_mode]);
    end

    // Present one input beat, after random idle cycles, and hold it until accepted.
    task automatic send_beat(input t_sample s, input logic fs, input logic chk,
                             input t_sample want);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 99) < SEND_IDLE_PCT[idle_mode]) begin
                i_in_valid <= 1'b0;
            end else begin
                break;
            end
        end
        i_in_valid    <= 1'b1;
        i_sample_in   <= s;
        i_frame_start <= fs;
        beat_chk      <= chk;
        beat_want     <= want;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        beats_sent++;
        idle_mode = (beats_sent < 200) ? 0 : (beats_sent < 400) ? 1 : 2;
    endtask

    // Full-range samples half the time, with extremes, small values and held runs mixed in.
    function automatic t_sample pick_sample();
        t_sample s;
        case ($urandom_range(0, 7))
            0: s = 16'sh7FFF;
            1: s = 16'sh8000;
            2: s = t_sample'($urandom_range(0, 15)) - 16'sd8;
            3: s = last_pick;
            default: s = t_sample'($urandom);
        endcase
        last_pick = s;
        return s;
    endfunction

    task automatic run_random(input int count, input int fs_odds);
        for (int n = 0; n < count; n++) begin
            send_beat(pick_sample(), ($urandom_range(0, fs_odds - 1) == 0), CHK_PRED, '0);
        end
    endtask

    // Let every predicted sample come out, then give the pipeline time to empty.
    task automatic drain_block();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_samples.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_resampler(input logic [STEP_W-1:0] step,
                                 input logic [COUNT_W-1:0] limit);
        drain_block();
        write_reg(CFG_PHASE_STEP, CFG_W'(step));
        write_reg(CFG_FRAME_LIMIT, CFG_W'(limit));
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table at the reset settings.
        for (int i = 0; i < ROW_N; i++) begin
            send_beat(directed_rows[i].smp, directed_rows[i].fs,
                      directed_rows[i].chk, directed_rows[i].want);
        end
        run_random(100, 40);

        // Step of exactly one: a sample out for every sample in; a limit of 4096.
        set_resampler(PHASE_UNITY, 13'd4096);
        run_random(100, 60);
        // Step above one lets the phase climb and wrap; small limit with frequent frames.
        set_resampler(STEP_MAX, 13'd5);
        run_random(100, 8);
        // Zero step never emits.
        set_resampler('0, FRAME_LIMIT_RST);
        run_random(20, 10);
        // Zero limit ignores every sample.
        set_resampler(PHASE_STEP_RST, '0);
        run_random(20, 10);
        // Random step and limit.
        set_resampler(STEP_W'($urandom_range(0, 32'h4000_0000)),
                      COUNT_W'($urandom_range(1, 40)));
        run_random(100, 30);
        // One output per frame.
        set_resampler(PHASE_STEP_RST, 13'd1);
        run_random(60, 3);
        set_resampler(STEP_THIRD, 13'd4096);
        run_random(80, 50);

        drain_block();
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Run limit: far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
